@@ src/tws_pkg.sv @@
`default_nettype none
package tws_pkg;

  localparam int MAX_TIMERS = 32;
  localparam int IDX_W      = $clog2(MAX_TIMERS);
  localparam int CNT_W      = $clog2(MAX_TIMERS + 1);
  localparam int SLOT_SHIFT = 4;
  localparam int SLOT_W     = 8;
  localparam int ORDER_W    = 16;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_KILL  = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  localparam logic REG_START_TICK = 1'b0;
  localparam logic REG_MIN_GAP    = 1'b1;

  localparam logic [15:0] GAP_RESET = 16'd16;
  localparam logic [ORDER_W-1:0] ORDER_LIMIT = '1;

  typedef struct packed {
    logic [3:0]         owner;
    logic [31:0]        id;
    logic [31:0]        interval;
    logic [31:0]        remaining;
    logic [31:0]        last_fire;
    logic [SLOT_W-1:0]  slot;
    logic [ORDER_W-1:0] order;
  } tws_entry_t;

  typedef struct packed {
    logic owner;
    logic id;
    logic interval;
    logic remaining;
    logic last_fire;
    logic slot;
    logic order;
  } tws_mask_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    tws_mask_t        mask;
    logic             vset;
    logic             vclr;
    tws_entry_t       data;
  } tws_wr_t;

  // Wheel slot of a tick relative to the origin
  function automatic logic [SLOT_W-1:0] slot_of(input logic [31:0] tick,
                                                 input logic [31:0] origin);
    logic [31:0] rel;
    rel = tick - origin;
    return rel[SLOT_SHIFT +: SLOT_W];
  endfunction

endpackage
`default_nettype wire

@@ src/tws_ifs.sv @@
`default_nettype none
interface tws_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [3:0]  owner;
  logic [31:0] timer_id;
  logic [31:0] interval;
  logic [31:0] call_count;
  logic [31:0] now_tick;
  modport source (output valid, operation, owner, timer_id, interval, call_count, now_tick,
                  input ready);
  modport sink (input valid, operation, owner, timer_id, interval, call_count, now_tick,
                output ready);
endinterface

interface tws_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic        ok;
  logic [3:0]  fired_owner;
  logic [31:0] fired_id;
  logic        last;
  modport source (output valid, kind, ok, fired_owner, fired_id, last, input ready);
  modport sink (input valid, kind, ok, fired_owner, fired_id, last, output ready);
endinterface

interface tws_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/timing_wheel_timer_scheduler_unit.sv @@
`default_nettype none
// A set scans every table entry, then fills the first free one for a new key; a kill scans
// up to its key. A check runs a selection scan per timer examined plus a final empty one, a
// due test per examined timer and an order step per re-slotted one, one table entry per cycle
// through one compare unit. A check inside the minimum gap or an unknown operation goes to
// the final status item at once; result stalls and renumbering a spent order sequence add more.
// Throughput: one item at a time; the next item is taken after the last result is queued.
// Reset (rst_n, synchronous): timer table empty, sequence zero, start tick 0, min gap 16.
module timing_wheel_timer_scheduler_unit (
  input wire logic    clk,
  input wire logic    rst_n,
  tws_in_if.sink      in_if,
  tws_out_if.source   out_if,
  tws_cfg_if.sink     cfg_if
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_SET_SCAN  = 11'b00000000010,
    ST_SET_WRITE = 11'b00000000100,
    ST_KILL_SCAN = 11'b00000001000,
    ST_CHK_SEL   = 11'b00000010000,
    ST_CHK_PROC  = 11'b00000100000,
    ST_CHK_ORD   = 11'b00001000000,
    ST_RN_A      = 11'b00010000000,
    ST_RN_B      = 11'b00100000000,
    ST_RN_W      = 11'b01000000000,
    ST_FIN       = 11'b10000000000
  } state_t;

  localparam logic [tws_pkg::IDX_W-1:0] LAST_IDX = tws_pkg::IDX_W'(tws_pkg::MAX_TIMERS - 1);

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [31:0] start_tick_r, last_check_r, last_check_nxt;
  logic [15:0] gap_r;
  logic [tws_pkg::ORDER_W-1:0] seq_r, seq_nxt;

  logic [3:0]  owner_r, owner_nxt;
  logic [31:0] id_r, id_nxt, ival_r, ival_nxt, count_r, count_nxt, now_r, now_nxt;

  logic [tws_pkg::IDX_W-1:0] idx_r, idx_nxt, free_r, free_nxt, best_r, best_nxt;
  logic [tws_pkg::IDX_W-1:0] a_r, a_nxt, cnt_r, cnt_nxt;
  logic [tws_pkg::CNT_W-1:0] n_r, n_nxt;
  logic dup_r, dup_nxt, free_ok_r, free_ok_nxt, found_r, found_nxt, fin_ok_r, fin_ok_nxt;
  logic ref_valid_r, ref_valid_nxt;
  logic [tws_pkg::ORDER_W-1:0] ref_ord_r, ref_ord_nxt, best_ord_r, best_ord_nxt;
  logic [tws_pkg::SLOT_W-1:0]  s0_r, s0_nxt, span_r, span_nxt, best_d_r, best_d_nxt;
  logic [tws_pkg::MAX_TIMERS-1:0] visited_r, visited_nxt;
  logic [tws_pkg::IDX_W-1:0] rank_r [tws_pkg::MAX_TIMERS];
  logic rank_we;

  logic out_valid_r, out_kind_r, out_ok_r, out_last_r;
  logic [3:0]  out_owner_r;
  logic [31:0] out_id_r;
  logic push, push_kind, push_ok, push_last, out_free;
  logic [3:0]  push_owner;
  logic [31:0] push_id;

  tws_pkg::tws_wr_t    wr;
  tws_pkg::tws_entry_t rd_entry;
  logic                rd_valid;
  logic [tws_pkg::IDX_W-1:0] rd_idx;

  logic [tws_pkg::SLOT_W-1:0] slot_dist;
  logic                       cand;
  logic [31:0]                rem_dec;

  tws_entry_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .rd_idx   (rd_idx),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_free     = !out_valid_r || out_if.ready;

  // Pick the table read address for the current step
  always_comb begin
    unique case (state_r)
      ST_CHK_PROC, ST_CHK_ORD: rd_idx = best_r;
      ST_RN_A:                 rd_idx = a_r;
      default:                 rd_idx = idx_r;
    endcase
  end

  assign slot_dist = rd_entry.slot - s0_r;
  assign cand      = rd_valid && !visited_r[idx_r] && (slot_dist <= span_r);
  assign rem_dec   = rd_entry.remaining - 32'd1;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ret_nxt        = ret_r;
    last_check_nxt = last_check_r;
    seq_nxt        = seq_r;
    owner_nxt      = owner_r;
    id_nxt         = id_r;
    ival_nxt       = ival_r;
    count_nxt      = count_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    free_nxt       = free_r;
    best_nxt       = best_r;
    a_nxt          = a_r;
    cnt_nxt        = cnt_r;
    n_nxt          = n_r;
    dup_nxt        = dup_r;
    free_ok_nxt    = free_ok_r;
    found_nxt      = found_r;
    fin_ok_nxt     = fin_ok_r;
    ref_valid_nxt  = ref_valid_r;
    ref_ord_nxt    = ref_ord_r;
    best_ord_nxt   = best_ord_r;
    s0_nxt         = s0_r;
    span_nxt       = span_r;
    best_d_nxt     = best_d_r;
    visited_nxt    = visited_r;
    rank_we        = 1'b0;
    wr             = '0;
    push           = 1'b0;
    push_kind      = 1'b0;
    push_ok        = 1'b0;
    push_owner     = '0;
    push_id        = '0;
    push_last      = 1'b1;

    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          owner_nxt = in_if.owner;
          id_nxt    = in_if.timer_id;
          ival_nxt  = (in_if.interval == 32'd0) ? 32'd1 : in_if.interval;
          count_nxt = in_if.call_count;
          now_nxt   = in_if.now_tick;
          idx_nxt   = '0;
          dup_nxt   = 1'b0;
          free_ok_nxt = 1'b0;
          found_nxt = 1'b0;
          fin_ok_nxt = 1'b0;
          priority if (in_if.operation == tws_pkg::OP_SET) begin
            state_nxt = ST_SET_SCAN;
          end else if (in_if.operation == tws_pkg::OP_KILL) begin
            state_nxt = ST_KILL_SCAN;
          end else if (in_if.operation == tws_pkg::OP_CHECK) begin
            if ((in_if.now_tick - last_check_r) < {16'd0, gap_r}) begin
              state_nxt = ST_FIN;
            end else begin
              s0_nxt         = tws_pkg::slot_of(last_check_r, start_tick_r);
              span_nxt       = tws_pkg::slot_of(in_if.now_tick, start_tick_r)
                               - tws_pkg::slot_of(last_check_r, start_tick_r);
              last_check_nxt = in_if.now_tick;
              visited_nxt    = '0;
              state_nxt      = ST_CHK_SEL;
            end
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end

      // Look for a duplicate key and the first free entry
      ST_SET_SCAN: begin
        if (rd_valid && rd_entry.owner == owner_r && rd_entry.id == id_r) dup_nxt = 1'b1;
        if (!rd_valid && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_nxt    = idx_r;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          if (dup_nxt || !free_ok_nxt) state_nxt = ST_SET_WRITE;
          else                         state_nxt = ST_SET_WRITE;
          fin_ok_nxt = !dup_nxt && free_ok_nxt;
          if (!fin_ok_nxt) state_nxt = ST_FIN;
        end
      end

      // Fill the free entry, renumbering first if the sequence is spent
      ST_SET_WRITE: begin
        if (seq_r == tws_pkg::ORDER_LIMIT) begin
          ret_nxt   = ST_SET_WRITE;
          a_nxt     = '0;
          n_nxt     = '0;
          state_nxt = ST_RN_A;
        end else begin
          wr.idx            = free_r;
          wr.mask           = '1;
          wr.vset           = 1'b1;
          wr.data.owner     = owner_r;
          wr.data.id        = id_r;
          wr.data.interval  = ival_r;
          wr.data.remaining = count_r;
          wr.data.last_fire = last_check_r;
          wr.data.slot      = tws_pkg::slot_of(last_check_r + ival_r, start_tick_r);
          wr.data.order     = seq_r;
          seq_nxt           = seq_r + 1'b1;
          state_nxt         = ST_FIN;
        end
      end

      // Find and drop the keyed timer
      ST_KILL_SCAN: begin
        idx_nxt = idx_r + 1'b1;
        if (rd_valid && rd_entry.owner == owner_r && rd_entry.id == id_r) begin
          wr.idx     = idx_r;
          wr.vclr    = 1'b1;
          fin_ok_nxt = 1'b1;
          state_nxt  = ST_FIN;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = ST_FIN;
        end
      end

      // Select the next unvisited timer by wheel distance, then order
      ST_CHK_SEL: begin
        if (cand && (!found_r || {slot_dist, rd_entry.order} < {best_d_r, best_ord_r})) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r;
          best_d_nxt   = slot_dist;
          best_ord_nxt = rd_entry.order;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          if (found_nxt) begin
            state_nxt = ST_CHK_PROC;
          end else begin
            fin_ok_nxt = 1'b1;
            state_nxt  = ST_FIN;
          end
        end
      end

      // Fire the selected timer if due
      ST_CHK_PROC: begin
        if ((now_r - rd_entry.last_fire) < rd_entry.interval) begin
          visited_nxt[best_r] = 1'b1;
          found_nxt           = 1'b0;
          idx_nxt             = '0;
          state_nxt           = ST_CHK_SEL;
        end else if (out_free) begin
          visited_nxt[best_r] = 1'b1;
          found_nxt           = 1'b0;
          idx_nxt             = '0;
          push                = 1'b1;
          push_kind           = 1'b1;
          push_ok             = 1'b1;
          push_owner          = rd_entry.owner;
          push_id             = rd_entry.id;
          push_last           = 1'b0;
          wr.idx              = best_r;
          wr.mask.last_fire   = 1'b1;
          wr.mask.remaining   = 1'b1;
          wr.data.last_fire   = now_r;
          wr.data.remaining   = rem_dec;
          if (rem_dec == 32'd0) begin
            wr.vclr   = 1'b1;
            state_nxt = ST_CHK_SEL;
          end else begin
            state_nxt = ST_CHK_ORD;
          end
        end
      end

      // Re-slot the fired timer
      ST_CHK_ORD: begin
        if (seq_r == tws_pkg::ORDER_LIMIT) begin
          ret_nxt   = ST_CHK_ORD;
          a_nxt     = '0;
          n_nxt     = '0;
          state_nxt = ST_RN_A;
        end else begin
          wr.idx        = best_r;
          wr.mask.slot  = 1'b1;
          wr.mask.order = 1'b1;
          wr.data.slot  = tws_pkg::slot_of(now_r + rd_entry.interval, start_tick_r);
          wr.data.order = seq_r;
          seq_nxt       = seq_r + 1'b1;
          idx_nxt       = '0;
          state_nxt     = ST_CHK_SEL;
        end
      end

      // Renumber: hold the reference order of entry a
      ST_RN_A: begin
        ref_valid_nxt = rd_valid;
        ref_ord_nxt   = rd_entry.order;
        idx_nxt       = '0;
        cnt_nxt       = '0;
        state_nxt     = ST_RN_B;
      end

      // Renumber: count valid entries ahead of entry a
      ST_RN_B: begin
        if (rd_valid && rd_entry.order < ref_ord_r) cnt_nxt = cnt_r + 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          rank_we = 1'b1;
          if (ref_valid_r) n_nxt = n_r + 1'b1;
          a_nxt = a_r + 1'b1;
          if (a_r == LAST_IDX) begin
            idx_nxt   = '0;
            state_nxt = ST_RN_W;
          end else begin
            state_nxt = ST_RN_A;
          end
        end
      end

      // Renumber: copy ranks into the order field
      ST_RN_W: begin
        wr.idx        = idx_r;
        wr.mask.order = rd_valid;
        wr.data.order = tws_pkg::ORDER_W'(rank_r[idx_r]);
        idx_nxt       = idx_r + 1'b1;
        if (idx_r == LAST_IDX) begin
          seq_nxt   = tws_pkg::ORDER_W'(n_r);
          state_nxt = ret_r;
        end
      end

      // Queue the final status item
      ST_FIN: begin
        if (out_free) begin
          push      = 1'b1;
          push_ok   = fin_ok_r;
          state_nxt = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ret_r        <= ST_IDLE;
      start_tick_r <= '0;
      last_check_r <= '0;
      gap_r        <= tws_pkg::GAP_RESET;
      seq_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      seq_r   <= seq_nxt;
      if (cfg_if.valid && cfg_if.index == tws_pkg::REG_START_TICK) begin
        start_tick_r <= cfg_if.data;
        last_check_r <= cfg_if.data;
      end else begin
        last_check_r <= last_check_nxt;
      end
      if (cfg_if.valid && cfg_if.index == tws_pkg::REG_MIN_GAP) gap_r <= cfg_if.data[15:0];
      if (push)              out_valid_r <= 1'b1;
      else if (out_if.ready) out_valid_r <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    owner_r     <= owner_nxt;
    id_r        <= id_nxt;
    ival_r      <= ival_nxt;
    count_r     <= count_nxt;
    now_r       <= now_nxt;
    idx_r       <= idx_nxt;
    free_r      <= free_nxt;
    best_r      <= best_nxt;
    a_r         <= a_nxt;
    cnt_r       <= cnt_nxt;
    n_r         <= n_nxt;
    dup_r       <= dup_nxt;
    free_ok_r   <= free_ok_nxt;
    found_r     <= found_nxt;
    fin_ok_r    <= fin_ok_nxt;
    ref_valid_r <= ref_valid_nxt;
    ref_ord_r   <= ref_ord_nxt;
    best_ord_r  <= best_ord_nxt;
    s0_r        <= s0_nxt;
    span_r      <= span_nxt;
    best_d_r    <= best_d_nxt;
    visited_r   <= visited_nxt;
    if (rank_we) rank_r[a_r] <= cnt_nxt;
    if (push) begin
      out_kind_r  <= push_kind;
      out_ok_r    <= push_ok;
      out_owner_r <= push_owner;
      out_id_r    <= push_id;
      out_last_r  <= push_last;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.kind        = out_kind_r;
  assign out_if.ok          = out_ok_r;
  assign out_if.fired_owner = out_owner_r;
  assign out_if.fired_id    = out_id_r;
  assign out_if.last        = out_last_r;

endmodule
`default_nettype wire

@@ src/tws_entry_table.sv @@
`default_nettype none
module tws_entry_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tws_pkg::tws_wr_t            wr,
  input  wire logic [tws_pkg::IDX_W-1:0]   rd_idx,
  output tws_pkg::tws_entry_t              rd_entry,
  output logic                             rd_valid
);

  logic [tws_pkg::MAX_TIMERS-1:0] valid_r;
  logic [3:0]                     owner_r     [tws_pkg::MAX_TIMERS];
  logic [31:0]                    id_r        [tws_pkg::MAX_TIMERS];
  logic [31:0]                    interval_r  [tws_pkg::MAX_TIMERS];
  logic [31:0]                    remaining_r [tws_pkg::MAX_TIMERS];
  logic [31:0]                    last_fire_r [tws_pkg::MAX_TIMERS];
  logic [tws_pkg::SLOT_W-1:0]     slot_r      [tws_pkg::MAX_TIMERS];
  logic [tws_pkg::ORDER_W-1:0]    order_r     [tws_pkg::MAX_TIMERS];

  // Valid bits clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.vset) begin
      valid_r[wr.idx] <= 1'b1;
    end else if (wr.vclr) begin
      valid_r[wr.idx] <= 1'b0;
    end
  end

  // Write selected fields
  always_ff @(posedge clk) begin
    if (wr.mask.owner)     owner_r[wr.idx]     <= wr.data.owner;
    if (wr.mask.id)        id_r[wr.idx]        <= wr.data.id;
    if (wr.mask.interval)  interval_r[wr.idx]  <= wr.data.interval;
    if (wr.mask.remaining) remaining_r[wr.idx] <= wr.data.remaining;
    if (wr.mask.last_fire) last_fire_r[wr.idx] <= wr.data.last_fire;
    if (wr.mask.slot)      slot_r[wr.idx]      <= wr.data.slot;
    if (wr.mask.order)     order_r[wr.idx]     <= wr.data.order;
  end

  // Single read port
  always_comb begin
    rd_valid           = valid_r[rd_idx];
    rd_entry.owner     = owner_r[rd_idx];
    rd_entry.id        = id_r[rd_idx];
    rd_entry.interval  = interval_r[rd_idx];
    rd_entry.remaining = remaining_r[rd_idx];
    rd_entry.last_fire = last_fire_r[rd_idx];
    rd_entry.slot      = slot_r[rd_idx];
    rd_entry.order     = order_r[rd_idx];
  end

endmodule
`default_nettype wire

@@ tb/sv/tws_checker.sv @@
`default_nettype none
module tws_checker
  import tws_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tws_in_if    in_mon,
  tws_out_if   out_mon,
  tws_cfg_if   cfg_mon,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WHEEL_SLOTS = 256;

  typedef struct packed {
    logic        kind;
    logic        ok;
    logic [3:0]  owner;
    logic [31:0] id;
    logic        last;
  } tws_result_t;

  tws_result_t expected_q[$];

  // Shadow copy of the scheduler state
  logic [31:0] origin;
  logic [15:0] min_gap;
  logic        tm_valid    [MAX_TIMERS];
  logic [3:0]  tm_owner    [MAX_TIMERS];
  logic [31:0] tm_id       [MAX_TIMERS];
  logic [31:0] tm_interval [MAX_TIMERS];
  logic [31:0] tm_left     [MAX_TIMERS];
  logic [31:0] tm_fired_at [MAX_TIMERS];
  logic [7:0]  tm_slot     [MAX_TIMERS];
  logic [15:0] tm_order    [MAX_TIMERS];
  logic [15:0] seq_next;
  logic [31:0] last_check;

  function automatic logic [7:0] wheel_slot(input logic [31:0] tick);
    logic [31:0] rel;
    rel = tick - origin;
    rel = rel >> SLOT_SHIFT;
    return rel[7:0];
  endfunction

  // Hand out the next append number; compact the numbering when it runs out
  function automatic logic [15:0] take_order();
    logic [15:0] rank [MAX_TIMERS];
    logic [15:0] live;
    live = 0;
    if (seq_next == 16'hFFFF) begin
      for (int a = 0; a < MAX_TIMERS; a++) begin
        rank[a] = 0;
        if (tm_valid[a]) begin
          for (int b = 0; b < MAX_TIMERS; b++)
            if (tm_valid[b] && tm_order[b] < tm_order[a]) rank[a]++;
          live++;
        end
      end
      for (int a = 0; a < MAX_TIMERS; a++)
        if (tm_valid[a]) tm_order[a] = rank[a];
      seq_next = live;
    end
    seq_next++;
    return seq_next - 16'd1;
  endfunction

  function automatic int find_timer(input logic [3:0] owner, input logic [31:0] id);
    for (int k = 0; k < MAX_TIMERS; k++)
      if (tm_valid[k] && tm_owner[k] == owner && tm_id[k] == id) return k;
    return -1;
  endfunction

  task automatic push_result(input logic kind, input logic ok, input logic [3:0] owner,
                             input logic [31:0] id, input logic last);
    tws_result_t r;
    r.kind = kind;
    r.ok = ok;
    r.owner = owner;
    r.id = id;
    r.last = last;
    expected_q.insert(expected_q.size(), r);
  endtask

  // Work out the results of one accepted item and update the shadow state
  task automatic predict_item(input logic [1:0] op, input logic [3:0] owner,
                              input logic [31:0] id, input logic [31:0] interval,
                              input logic [31:0] count, input logic [31:0] now);
    int          k;
    int          best;
    logic        done;
    logic        visited [MAX_TIMERS];
    logic [7:0]  s;
    logic [7:0]  cur;
    logic [31:0] ivl;
    if (op == OP_SET) begin
      k = -1;
      if (find_timer(owner, id) < 0) begin
        for (int j = MAX_TIMERS - 1; j >= 0; j--)
          if (!tm_valid[j]) k = j;
      end
      if (k >= 0) begin
        ivl = (interval == 0) ? 32'd1 : interval;
        tm_owner[k] = owner;
        tm_id[k] = id;
        tm_interval[k] = ivl;
        tm_left[k] = count;
        tm_fired_at[k] = last_check;
        tm_slot[k] = wheel_slot(last_check + ivl);
        tm_order[k] = take_order();
        tm_valid[k] = 1'b1;
      end
      push_result(1'b0, k >= 0, 4'd0, 32'd0, 1'b1);
    end else if (op == OP_KILL) begin
      k = find_timer(owner, id);
      if (k >= 0) tm_valid[k] = 1'b0;
      push_result(1'b0, k >= 0, 4'd0, 32'd0, 1'b1);
    end else if (op == OP_CHECK) begin
      if (now - last_check < {16'd0, min_gap}) begin
        push_result(1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
      end else begin
        s = wheel_slot(last_check);
        cur = wheel_slot(now);
        last_check = now;
        for (int j = 0; j < MAX_TIMERS; j++) visited[j] = 1'b0;
        // Walk the slots up to and including the current one
        for (int step = 0; step < WHEEL_SLOTS; step++) begin
          done = 1'b0;
          while (!done) begin
            best = -1;
            for (int j = 0; j < MAX_TIMERS; j++)
              if (tm_valid[j] && !visited[j] && tm_slot[j] == s)
                if (best < 0 || tm_order[j] < tm_order[best]) best = j;
            if (best < 0) begin
              done = 1'b1;
            end else begin
              visited[best] = 1'b1;
              if (now - tm_fired_at[best] >= tm_interval[best]) begin
                tm_fired_at[best] = now;
                tm_left[best] = tm_left[best] - 32'd1;
                push_result(1'b1, 1'b1, tm_owner[best], tm_id[best], 1'b0);
                if (tm_left[best] == 0) begin
                  tm_valid[best] = 1'b0;
                end else begin
                  tm_slot[best] = wheel_slot(now + tm_interval[best]);
                  tm_order[best] = take_order();
                end
              end
            end
          end
          if (s == cur) break;
          s = s + 8'd1;
        end
        push_result(1'b0, 1'b1, 4'd0, 32'd0, 1'b1);
      end
    end else begin
      push_result(1'b0, 1'b0, 4'd0, 32'd0, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    tws_result_t exp_r;
    tws_result_t got_r;
    if (!rst_n) begin
      expected_q.delete();
      origin = 32'd0;
      min_gap = GAP_RESET;
      for (int j = 0; j < MAX_TIMERS; j++) tm_valid[j] = 1'b0;
      seq_next = 16'd0;
      last_check = 32'd0;
    end else begin
      // Track register writes
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == REG_START_TICK) begin
          origin = cfg_mon.data;
          last_check = cfg_mon.data;
        end else begin
          min_gap = cfg_mon.data[15:0];
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_item(in_mon.operation, in_mon.owner, in_mon.timer_id, in_mon.interval,
                     in_mon.call_count, in_mon.now_tick);
      // Compare each result with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        got_r.kind = out_mon.kind;
        got_r.ok = out_mon.ok;
        got_r.owner = out_mon.fired_owner;
        got_r.id = out_mon.fired_id;
        got_r.last = out_mon.last;
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result kind=%0b ok=%0b owner=%0d id=%h last=%0b",
                     $realtime, got_r.kind, got_r.ok, got_r.owner, got_r.id, got_r.last);
        end else begin
          exp_r = expected_q.pop_front();
          if (got_r !== exp_r) begin
            fail_count++;
            if (fail_count <= 10) begin
              $write("[%0t] result mismatch: expected kind=%0b ok=%0b owner=%0d id=%h ",
                     $realtime, exp_r.kind, exp_r.ok, exp_r.owner, exp_r.id);
              $display("last=%0b, got kind=%0b ok=%0b owner=%0d id=%h last=%0b",
                       exp_r.last, got_r.kind, got_r.ok, got_r.owner, got_r.id, got_r.last);
            end
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_timing_wheel_timer_scheduler_unit.sv @@
`default_nettype none
module tb_timing_wheel_timer_scheduler_unit;
  import tws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst_n;
  logic calm;
  int   fail_count;
  int   pending;
  int   quiet_cycles;
  logic [31:0] tick_now;
  logic [31:0] phase_start;
  logic [15:0] phase_gap;

  tws_in_if  in_ch();
  tws_out_if out_ch();
  tws_cfg_if cfg_ch();

  timing_wheel_timer_scheduler_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  tws_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer one item and hold it until taken
  task automatic send_item(input logic [1:0] op, input logic [3:0] owner,
                           input logic [31:0] id, input logic [31:0] interval,
                           input logic [31:0] count, input logic [31:0] now);
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.owner <= owner;
    in_ch.timer_id <= id;
    in_ch.interval <= interval;
    in_ch.call_count <= count;
    in_ch.now_tick <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic index, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_key(output logic [3:0] owner, output logic [31:0] id);
    if ($urandom_range(0, 9) == 0) begin
      owner = $urandom_range(0, 15);
      id = $urandom;
    end else begin
      owner = $urandom_range(0, 3);
      id = $urandom_range(0, 7);
    end
  endtask

  // One random operation, mostly sets and checks that advance the tick
  task automatic random_item();
    logic [3:0]  owner;
    logic [31:0] id;
    logic [31:0] ivl;
    logic [31:0] cnt;
    int          pick;
    random_key(owner, id);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ivl = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 120);
      case ($urandom_range(0, 19))
        0: cnt = 32'd0;
        1: cnt = $urandom;
        default: cnt = $urandom_range(1, 4);
      endcase
      send_item(OP_SET, owner, id, ivl, cnt, $urandom);
    end else if (pick < 55) begin
      send_item(OP_KILL, owner, id, $urandom, $urandom, $urandom);
    end else begin
      if ($urandom_range(0, 9) == 0)
        tick_now = tick_now + $urandom_range(0, 32'(phase_gap));
      else if ($urandom_range(0, 19) == 0)
        tick_now = tick_now + $urandom_range(4096, 70000);
      else
        tick_now = tick_now + 32'(phase_gap) + $urandom_range(0, 60);
      send_item(OP_CHECK, owner, id, $urandom, $urandom, tick_now);
    end
  endtask

  // Result side: random stall bursts, one long hold to back up the input
  initial begin
    int taken;
    int stall;
    logic held;
    taken = 0;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && taken >= 60) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 11);
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
        if (out_ch.valid && out_ch.ready) taken++;
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] starts [4];
    logic [15:0] gaps   [4];
    calm = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_SET;
    in_ch.owner = 4'd0;
    in_ch.timer_id = 32'd0;
    in_ch.interval = 32'd0;
    in_ch.call_count = 32'd0;
    in_ch.now_tick = 32'd0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_START_TICK;
    cfg_ch.data = 32'd0;
    phase_gap = GAP_RESET;
    tick_now = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero interval, duplicate, extremes, zero count, misses
    send_item(OP_SET, 4'd0, 32'd0, 32'd0, 32'd2, 32'd0);
    send_item(OP_SET, 4'd0, 32'd0, 32'd9, 32'd1, 32'd0);
    send_item(OP_SET, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_SET, 4'd1, 32'd5, 32'd1, 32'd3, 32'd0);
    send_item(OP_SET, 4'd2, 32'd7, 32'd40, 32'd0, 32'd0);
    send_item(OP_KILL, 4'd3, 32'd9, 32'd0, 32'd0, 32'd0);
    send_item(OP_CHECK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd5);
    send_item(OP_CHECK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd20);
    send_item(OP_CHECK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd41);
    send_item(OP_KILL, 4'd15, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
    send_item(OP_SPARE, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(OP_CHECK, 4'd0, 32'd0, 32'd0, 32'd0, 32'd20000);
    send_item(OP_KILL, 4'd2, 32'd7, 32'd0, 32'd0, 32'd0);
    send_item(OP_KILL, 4'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    tick_now = 32'd20000;

    // Fill the table past capacity, then empty it
    for (int i = 0; i < MAX_TIMERS + 2; i++)
      send_item(OP_SET, 4'(i), 32'h8000_0000 + i, 32'd5000, 32'd1, tick_now);
    for (int i = 0; i < MAX_TIMERS + 2; i++)
      send_item(OP_KILL, 4'(i), 32'h8000_0000 + i, 32'd0, 32'd0, tick_now);
    drain();

    // Random phases under different origins and check spacings
    starts[0] = 32'd0;        gaps[0] = 16'd0;
    starts[1] = 32'hFFFF_FF00; gaps[1] = 16'hFFFF;
    starts[2] = $urandom;     gaps[2] = $urandom_range(1, 200);
    starts[3] = 32'hFFFF_FFFF; gaps[3] = GAP_RESET;
    for (int p = 0; p < 4; p++) begin
      write_reg(REG_START_TICK, starts[p]);
      write_reg(REG_MIN_GAP, {16'd0, gaps[p]});
      tick_now = starts[p];
      phase_gap = gaps[p];
      if (p == 3) calm = 1'b1;
      for (int i = 0; i < 45; i++) random_item();
      drain();
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
src/tws_pkg.sv
src/tws_ifs.sv
src/tws_entry_table.sv
src/timing_wheel_timer_scheduler_unit.sv
tb/sv/tws_checker.sv
tb/sv/tb_timing_wheel_timer_scheduler_unit.sv
